### rtl/pau_pkg.sv
// Shared constants, codes and types of the Pareto archive update block.
package pau_pkg;

    localparam int CAPACITY   = 64;
    localparam int NUM_OBJ    = 4;
    localparam int VALUE_BITS = 32;
    localparam int TAG_W      = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W    = TAG_W + NUM_OBJ * VALUE_BITS;
    localparam int NOBJ_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int SIZE_W     = 7;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 3'd4;

    localparam logic       KIND_OFFER = 1'b0;
    localparam logic       KIND_READ  = 1'b1;

    localparam logic       CFG_DIR    = 1'b0;
    localparam logic       CFG_ACTIVE = 1'b1;

    typedef struct packed {
        logic s_win;
        logic c_win;
    } t_cmp;

    typedef struct packed {
        logic s_dom;
        logic c_dom;
    } t_dom;

endpackage

### rtl/pau_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pau_lane.sv
// One objective lane: compares a stored value against the candidate value.
module pau_lane (
    input  logic [pau_pkg::VALUE_BITS-1:0] i_stored,
    input  logic [pau_pkg::VALUE_BITS-1:0] i_cand,
    input  logic                           i_max,
    input  logic                           i_active,
    output pau_pkg::t_cmp                  o_cmp
);

    logic s_lt;
    logic c_lt;

    assign s_lt = $signed(i_stored) < $signed(i_cand);
    assign c_lt = $signed(i_cand) < $signed(i_stored);

    assign o_cmp.s_win = i_active & (i_max ? c_lt : s_lt);
    assign o_cmp.c_win = i_active & (i_max ? s_lt : c_lt);

endmodule

### rtl/pau_merge.sv
// Merge of lane results into strict dominance in both directions.
module pau_merge (
    input  pau_pkg::t_cmp i_cmp [pau_pkg::NUM_OBJ],
    output pau_pkg::t_dom o_dom
);

    logic [pau_pkg::NUM_OBJ-1:0] s_any;
    logic [pau_pkg::NUM_OBJ-1:0] c_any;

    always_comb begin
        for (int k = 0; k < pau_pkg::NUM_OBJ; k++) begin
            s_any[k] = i_cmp[k].s_win;
            c_any[k] = i_cmp[k].c_win;
        end
    end

    assign o_dom.s_dom = (|s_any) & ~(|c_any);
    assign o_dom.c_dom = (|c_any) & ~(|s_any);

endmodule

### rtl/pareto_archive_update_core.sv
// Pareto archive update core: top level with control, banked storage and objective lanes.
// An offer scans every stored entry, one per cycle, through NUM_OBJ comparison lanes
// while survivors are copied into the spare bank. No new offer or read is accepted until
// the previous result has moved to the output register, so output stalls delay both.
// The spare bank becomes the live bank when an offer is inserted.
module pareto_archive_update_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [3:0]                            i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_kind,
    input  logic [5:0]                            i_index,
    input  logic [pau_pkg::TAG_W-1:0]             i_tag,
    input  logic signed [pau_pkg::VALUE_BITS-1:0] i_obj_0,
    input  logic signed [pau_pkg::VALUE_BITS-1:0] i_obj_1,
    input  logic signed [pau_pkg::VALUE_BITS-1:0] i_obj_2,
    input  logic signed [pau_pkg::VALUE_BITS-1:0] i_obj_3,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [pau_pkg::STATUS_W-1:0]          o_status,
    output logic [pau_pkg::SIZE_W-1:0]            o_removed_count,
    output logic [pau_pkg::SIZE_W-1:0]            o_front_size,
    output logic [pau_pkg::TAG_W-1:0]             o_entry_tag,
    output logic signed [pau_pkg::VALUE_BITS-1:0] o_entry_obj_0,
    output logic signed [pau_pkg::VALUE_BITS-1:0] o_entry_obj_1,
    output logic signed [pau_pkg::VALUE_BITS-1:0] o_entry_obj_2,
    output logic signed [pau_pkg::VALUE_BITS-1:0] o_entry_obj_3
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int VB = pau_pkg::VALUE_BITS;
    localparam int NO = pau_pkg::NUM_OBJ;

    logic [2:0]                       r_state;
    logic [3:0]                       r_dir;
    logic [pau_pkg::NOBJ_W-1:0]       r_act;
    logic                             r_bank;
    logic [pau_pkg::CNT_W-1:0]        r_count;
    logic [pau_pkg::CNT_W-1:0]        r_rd_ptr;
    logic [pau_pkg::CNT_W-1:0]        r_wr_ptr;
    logic [pau_pkg::CNT_W-1:0]        r_removed;
    logic                             r_chk;
    logic                             r_rej;
    logic [pau_pkg::ADDR_W-1:0]       r_idx;
    logic [VB-1:0]                    r_cand [NO];
    logic [pau_pkg::TAG_W-1:0]        r_cand_tag;
    logic [pau_pkg::STATUS_W-1:0]     r_res_status;
    logic [pau_pkg::SIZE_W-1:0]       r_res_removed;
    logic [pau_pkg::SIZE_W-1:0]       r_res_size;
    logic [pau_pkg::ENTRY_W-1:0]      r_res_entry;
    logic                             r_out_valid;
    logic [pau_pkg::STATUS_W-1:0]     r_out_status;
    logic [pau_pkg::SIZE_W-1:0]       r_out_removed;
    logic [pau_pkg::SIZE_W-1:0]       r_out_size;
    logic [pau_pkg::ENTRY_W-1:0]      r_out_entry;

    logic                             in_acc;
    logic                             out_free;
    logic                             ins_ok;
    logic [pau_pkg::NOBJ_W-1:0]       n_used;
    logic [pau_pkg::ADDR_W-1:0]       rd_addr;
    logic [pau_pkg::ENTRY_W-1:0]      rdata0;
    logic [pau_pkg::ENTRY_W-1:0]      rdata1;
    logic [pau_pkg::ENTRY_W-1:0]      rdata;
    logic [pau_pkg::ENTRY_W-1:0]      cand_entry;
    logic                             we;
    logic [pau_pkg::ENTRY_W-1:0]      wdata;
    pau_pkg::t_cmp                    cmp [NO];
    pau_pkg::t_dom                    dom;

    assign in_acc   = i_valid & ~o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = ~r_out_valid | ~i_stall;
    assign ins_ok   = ~r_rej & ~((r_removed == '0)
                      & (r_count == pau_pkg::CNT_W'(pau_pkg::CAPACITY)));

    always_comb begin
        if (r_act == '0) begin
            n_used = pau_pkg::NOBJ_W'(1);
        end else if (r_act > pau_pkg::NOBJ_W'(NO)) begin
            n_used = pau_pkg::NOBJ_W'(NO);
        end else begin
            n_used = r_act;
        end
    end

    always_comb begin
        cand_entry = '0;
        cand_entry[pau_pkg::ENTRY_W-1 -: pau_pkg::TAG_W] = r_cand_tag;
        for (int k = 0; k < NO; k++) begin
            cand_entry[k*VB +: VB] = r_cand[k];
        end
    end

    assign rd_addr = (r_state == S_IDLE) ? i_index[pau_pkg::ADDR_W-1:0]
                                         : r_rd_ptr[pau_pkg::ADDR_W-1:0];
    assign rdata   = r_bank ? rdata1 : rdata0;
    assign we      = ((r_state == S_SCAN) & r_chk & ~dom.c_dom)
                   | ((r_state == S_FIN) & ins_ok);
    assign wdata   = (r_state == S_SCAN) ? rdata : cand_entry;

    pau_ram #(.WIDTH(pau_pkg::ENTRY_W), .DEPTH(pau_pkg::CAPACITY)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we & r_bank),
        .i_waddr (r_wr_ptr[pau_pkg::ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata0)
    );

    pau_ram #(.WIDTH(pau_pkg::ENTRY_W), .DEPTH(pau_pkg::CAPACITY)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we & ~r_bank),
        .i_waddr (r_wr_ptr[pau_pkg::ADDR_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata1)
    );

    for (genvar k = 0; k < NO; k++) begin : g_lane
        pau_lane u_lane (
            .i_stored (rdata[k*VB +: VB]),
            .i_cand   (r_cand[k]),
            .i_max    (r_dir[k]),
            .i_active (pau_pkg::NOBJ_W'(k) < n_used),
            .o_cmp    (cmp[k])
        );
    end

    pau_merge u_merge (
        .i_cmp (cmp),
        .o_dom (dom)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dir       <= '0;
            r_act       <= pau_pkg::NOBJ_W'(4);
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pau_pkg::CFG_DIR:    r_dir <= i_cfg_data;
                    pau_pkg::CFG_ACTIVE: r_act <= i_cfg_data[pau_pkg::NOBJ_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cand[0]  <= i_obj_0;
                        r_cand[1]  <= i_obj_1;
                        r_cand[2]  <= i_obj_2;
                        r_cand[3]  <= i_obj_3;
                        r_cand_tag <= i_tag;
                        r_idx      <= i_index[pau_pkg::ADDR_W-1:0];
                        r_rd_ptr   <= '0;
                        r_wr_ptr   <= '0;
                        r_removed  <= '0;
                        r_rej      <= 1'b0;
                        r_chk      <= 1'b0;
                        r_state    <= (i_kind == pau_pkg::KIND_READ) ? S_RD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_chk) begin
                        if (dom.s_dom) begin
                            r_rej <= 1'b1;
                        end
                        if (dom.c_dom) begin
                            r_removed <= r_removed + 1'b1;
                        end else begin
                            r_wr_ptr <= r_wr_ptr + 1'b1;
                        end
                    end
                    if (r_rd_ptr < r_count) begin
                        r_rd_ptr <= r_rd_ptr + 1'b1;
                        r_chk    <= 1'b1;
                    end else begin
                        r_chk <= 1'b0;
                        if (!r_chk) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_res_entry <= '0;
                    if (r_rej) begin
                        r_res_status  <= pau_pkg::ST_REJECTED;
                        r_res_removed <= '0;
                        r_res_size    <= pau_pkg::SIZE_W'(r_count);
                    end else if (!ins_ok) begin
                        r_res_status  <= pau_pkg::ST_FULL;
                        r_res_removed <= '0;
                        r_res_size    <= pau_pkg::SIZE_W'(r_count);
                    end else begin
                        r_res_status  <= pau_pkg::ST_INSERTED;
                        r_res_removed <= pau_pkg::SIZE_W'(r_removed);
                        r_res_size    <= pau_pkg::SIZE_W'(r_wr_ptr + 1'b1);
                        r_count       <= r_wr_ptr + 1'b1;
                        r_bank        <= ~r_bank;
                    end
                    r_state <= S_DONE;
                end
                S_RD: begin
                    r_res_removed <= '0;
                    r_res_size    <= pau_pkg::SIZE_W'(r_count);
                    if (pau_pkg::CNT_W'(r_idx) < r_count) begin
                        r_res_status <= pau_pkg::ST_READ_OK;
                        r_res_entry  <= rdata;
                    end else begin
                        r_res_status <= pau_pkg::ST_OUT_RANGE;
                        r_res_entry  <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_res_status;
                        r_out_removed <= r_res_removed;
                        r_out_size    <= r_res_size;
                        r_out_entry   <= r_res_entry;
                        r_state       <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_count = r_out_removed;
    assign o_front_size    = r_out_size;
    assign o_entry_tag     = r_out_entry[pau_pkg::ENTRY_W-1 -: pau_pkg::TAG_W];
    assign o_entry_obj_0   = r_out_entry[0*VB +: VB];
    assign o_entry_obj_1   = r_out_entry[1*VB +: VB];
    assign o_entry_obj_2   = r_out_entry[2*VB +: VB];
    assign o_entry_obj_3   = r_out_entry[3*VB +: VB];

endmodule

### rtl/pau_checker.sv
// Port-level checker of the Pareto archive update core, bound to the top level.
module pau_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [pau_pkg::STATUS_W-1:0]  o_status,
    input logic [pau_pkg::SIZE_W-1:0]    o_removed_count,
    input logic [pau_pkg::SIZE_W-1:0]    o_front_size,
    input logic [pau_pkg::TAG_W-1:0]     o_entry_tag
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_front_size))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not blocked after accept");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_front_size <= pau_pkg::SIZE_W'(pau_pkg::CAPACITY)
                    && o_status <= pau_pkg::ST_OUT_RANGE)
        else $error("result field out of range");

    a_removed_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != pau_pkg::ST_INSERTED |-> o_removed_count == '0)
        else $error("evictions reported without insert");

    a_tag_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != pau_pkg::ST_READ_OK |-> o_entry_tag == '0)
        else $error("entry data on non-read result");

endmodule

bind pareto_archive_update_core pau_checker u_pau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_removed_count (o_removed_count),
    .o_front_size    (o_front_size),
    .o_entry_tag     (o_entry_tag)
);

### test/tb_pareto_archive_update_core.sv
// Testbench for the Pareto archive update core: directed and random offers and reads.
`timescale 1ns / 1ps
module tb_pareto_archive_update_core;
    import pau_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [SIZE_W-1:0]            removed_count;
        logic [SIZE_W-1:0]            front_size;
        logic [TAG_W-1:0]             entry_tag;
        logic signed [VALUE_BITS-1:0] entry_obj_0;
        logic signed [VALUE_BITS-1:0] entry_obj_1;
        logic signed [VALUE_BITS-1:0] entry_obj_2;
        logic signed [VALUE_BITS-1:0] entry_obj_3;
    } t_archive_result;

    typedef logic signed [VALUE_BITS-1:0] t_vec [NUM_OBJ];

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_index = CFG_DIR;
    logic [3:0]                    i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_kind = KIND_OFFER;
    logic [5:0]                    i_index = '0;
    logic [TAG_W-1:0]              i_tag = '0;
    logic signed [VALUE_BITS-1:0]  i_obj_0 = '0, i_obj_1 = '0, i_obj_2 = '0, i_obj_3 = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [STATUS_W-1:0]           o_status;
    logic [SIZE_W-1:0]             o_removed_count, o_front_size;
    logic [TAG_W-1:0]              o_entry_tag;
    logic signed [VALUE_BITS-1:0]  o_entry_obj_0, o_entry_obj_1, o_entry_obj_2, o_entry_obj_3;

    pareto_archive_update_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_vec            front_obj [CAPACITY];
    logic [TAG_W-1:0] front_tag [CAPACITY];
    int              front_len = 0;
    logic [3:0]      dir_mask = 4'd0;
    logic [2:0]      active_cnt = 3'd4;

    t_archive_result pending_results [$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  quiet_sender = 0;
    bit  quiet_receiver = 0;

    function automatic bit dominates(t_vec a, t_vec b);
        int n;
        bit better;
        n = (active_cnt == 0) ? 1 : (active_cnt > NUM_OBJ ? NUM_OBJ : active_cnt);
        better = 0;
        for (int k = 0; k < n; k++) begin
            if (dir_mask[k] ? (b[k] > a[k]) : (b[k] < a[k])) return 0;
            if (dir_mask[k] ? (a[k] > b[k]) : (a[k] < b[k])) better = 1;
        end
        return better;
    endfunction

    function automatic t_archive_result update_archive(logic kind, logic [5:0] idx,
            logic [TAG_W-1:0] tag, t_vec c);
        t_archive_result r;
        int removed, w;
        r = '0;
        if (kind == KIND_READ) begin
            if (idx < front_len) begin
                r.status = ST_READ_OK;
                r.entry_tag = front_tag[idx];
                r.entry_obj_0 = front_obj[idx][0];
                r.entry_obj_1 = front_obj[idx][1];
                r.entry_obj_2 = front_obj[idx][2];
                r.entry_obj_3 = front_obj[idx][3];
            end else begin
                r.status = ST_OUT_RANGE;
            end
            r.front_size = SIZE_W'(front_len);
            return r;
        end
        for (int i = 0; i < front_len; i++)
            if (dominates(front_obj[i], c)) begin
                r.status = ST_REJECTED;
                r.front_size = SIZE_W'(front_len);
                return r;
            end
        removed = 0;
        for (int i = 0; i < front_len; i++)
            if (dominates(c, front_obj[i])) removed++;
        if (removed == 0 && front_len >= CAPACITY) begin
            r.status = ST_FULL;
            r.front_size = SIZE_W'(front_len);
            return r;
        end
        w = 0;
        for (int i = 0; i < front_len; i++)
            if (!dominates(c, front_obj[i])) begin
                front_obj[w] = front_obj[i];
                front_tag[w] = front_tag[i];
                w++;
            end
        front_obj[w] = c;
        front_tag[w] = tag;
        front_len = w + 1;
        r.status = ST_INSERTED;
        r.removed_count = SIZE_W'(removed);
        r.front_size = SIZE_W'(front_len);
        return r;
    endfunction

    task automatic send_item(logic kind, logic [5:0] idx, logic [TAG_W-1:0] tag, t_vec c);
        int gap;
        t_archive_result exp_res;
        gap = quiet_sender ? 0 : $urandom_range(0, 16);
        repeat (gap) @(posedge i_clk);
        exp_res = update_archive(kind, idx, tag, c);
        pending_results = {pending_results, exp_res};
        i_valid <= 1'b1;
        i_kind <= kind;
        i_index <= idx;
        i_tag <= tag;
        i_obj_0 <= c[0];
        i_obj_1 <= c[1];
        i_obj_2 <= c[2];
        i_obj_3 <= c[3];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic offer(logic [TAG_W-1:0] tag, t_vec c);
        send_item(KIND_OFFER, 6'($urandom_range(0, 63)), tag, c);
    endtask

    task automatic read_at(logic [5:0] idx);
        t_vec c;
        foreach (c[k]) c[k] = $urandom;
        send_item(KIND_READ, idx, TAG_W'($urandom), c);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic index, logic [3:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_DIR) dir_mask = data;
        else active_cnt = data[2:0];
        @(posedge i_clk);
    endtask

    // receiver stall and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected");
                    fail_count++;
                end else begin
                    t_archive_result e;
                    e = pending_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); fail_count++;
                    end
                    if (o_removed_count !== e.removed_count) begin
                        $error("removed_count exp %0d got %0d", e.removed_count,
                               o_removed_count); fail_count++;
                    end
                    if (o_front_size !== e.front_size) begin
                        $error("front_size exp %0d got %0d", e.front_size, o_front_size);
                        fail_count++;
                    end
                    if (o_entry_tag !== e.entry_tag) begin
                        $error("entry_tag exp %0h got %0h", e.entry_tag, o_entry_tag);
                        fail_count++;
                    end
                    if (o_entry_obj_0 !== e.entry_obj_0) begin
                        $error("entry_obj_0 exp %0h got %0h", e.entry_obj_0, o_entry_obj_0);
                        fail_count++;
                    end
                    if (o_entry_obj_1 !== e.entry_obj_1) begin
                        $error("entry_obj_1 exp %0h got %0h", e.entry_obj_1, o_entry_obj_1);
                        fail_count++;
                    end
                    if (o_entry_obj_2 !== e.entry_obj_2) begin
                        $error("entry_obj_2 exp %0h got %0h", e.entry_obj_2, o_entry_obj_2);
                        fail_count++;
                    end
                    if (o_entry_obj_3 !== e.entry_obj_3) begin
                        $error("entry_obj_3 exp %0h got %0h", e.entry_obj_3, o_entry_obj_3);
                        fail_count++;
                    end
                end
            end
            if (o_valid && !i_stall) begin
                int wait_n;
                wait_n = quiet_receiver ? 0 : $urandom_range(0, 16);
                stall_left <= wait_n;
                i_stall <= (wait_n != 0);
            end else if (i_stall) begin
                stall_left <= stall_left - 1;
                if (stall_left <= 1) i_stall <= 1'b0;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 4000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic t_vec small_vec();
        t_vec c;
        foreach (c[k]) c[k] = $signed($urandom_range(0, 6)) - 3;
        return c;
    endfunction

    function automatic t_vec wide_vec();
        t_vec c;
        foreach (c[k]) c[k] = $urandom;
        return c;
    endfunction

    task automatic test_directed();
        t_vec c;
        read_at(0);
        c = '{32'sh7fffffff, 32'sh80000000, 0, -1};
        offer(16'hffff, c);
        offer(16'h0000, c);
        read_at(0);
        read_at(1);
        read_at(2);
        read_at(63);
        c = '{32'sh80000000, 32'sh80000000, 0, -1};
        offer(16'h1234, c);
        c = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        offer(16'h5555, c);
        c = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
        offer(16'haaaa, c);
        read_at(0);
        drain();
    endtask

    task automatic test_full_archive();
        t_vec c;
        write_cfg(CFG_DIR, 4'b0000);
        write_cfg(CFG_ACTIVE, 4'd2);
        // antichain fills the archive
        for (int i = 0; i < CAPACITY + 3; i++) begin
            c = '{i, -i, $urandom, $urandom};
            offer(TAG_W'(i), c);
        end
        read_at(63);
        c = '{-100, -100, 0, 0};
        offer(16'hbeef, c);
        read_at(0);
        drain();
    endtask

    task automatic test_random();
        t_vec c;
        logic [3:0] dirs [5] = '{4'b0000, 4'b1111, 4'b0101, 4'b1010, 4'b0011};
        logic [2:0] acts [5] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3};
        for (int p = 0; p < 5; p++) begin
            write_cfg(CFG_DIR, dirs[p]);
            write_cfg(CFG_ACTIVE, 4'(acts[p]));
            quiet_sender = (p == 2);
            quiet_receiver = (p == 3);
            for (int n = 0; n < 300; n++) begin
                if ($urandom_range(0, 3) == 0)
                    read_at(6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                         : $urandom_range(0, front_len)));
                else begin
                    c = ($urandom_range(0, 7) == 0) ? wide_vec() : small_vec();
                    offer(TAG_W'($urandom), c);
                end
                if (n == 150) drain();
            end
            drain();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_archive();
        test_random();
        if (fail_count == 0 && pending_results.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
